[rtl/core/nmt_pkg.sv]
// shared types and constants for the numeric text normalizer
// no dependencies; imported by every module of the block
package nmt_pkg;

    // parse phase codes
    localparam logic [3:0] PH_LEAD  = 4'd0;
    localparam logic [3:0] PH_LZ    = 4'd1;
    localparam logic [3:0] PH_INT   = 4'd2;
    localparam logic [3:0] PH_FRAC  = 4'd3;
    localparam logic [3:0] PH_EXPS  = 4'd4;
    localparam logic [3:0] PH_EXP   = 4'd5;
    localparam logic [3:0] PH_DRAIN = 4'd6;

    // character constants
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       is_char;
        logic       is_end;
        logic       accepted;
    } result_t;

    // parser state
    typedef struct packed {
        logic [3:0] phase;
        logic       zeros_only;
        logic       need_frac;
    } parse_state_t;

    // what one input byte produces
    typedef struct packed {
        logic [1:0]   n;
        result_t      r0;
        result_t      r1;
        parse_state_t nxt;
    } step_t;

endpackage

[rtl/core/nmt_step.sv]
// per-byte parse logic: current state and byte in, results and next state out
// depends on nmt_pkg
module nmt_step import nmt_pkg::*; (
    input  parse_state_t st,
    input  logic [7:0]   ch,
    output step_t        step
);

    logic       is_nul;
    logic       is_dig;
    logic       is_spc;
    logic       is_em;
    logic [3:0] eff_phase;
    logic       eff_zo;

    function automatic result_t chr(input logic [7:0] c);
        result_t r;
        r.out_char = c;
        r.is_char  = 1'b1;
        r.is_end   = 1'b0;
        r.accepted = 1'b0;
        return r;
    endfunction

    function automatic result_t fin(input logic ok);
        result_t r;
        r.out_char = CH_NUL;
        r.is_char  = 1'b0;
        r.is_end   = 1'b1;
        r.accepted = ok;
        return r;
    endfunction

    // byte classes
    assign is_nul = (ch == CH_NUL);
    assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_spc = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_em  = (ch == CH_LE) || (ch == CH_UE);

    // leading phase falls through into integer start with a clean zero flag
    assign eff_phase = (st.phase == PH_LEAD) ? PH_LZ : st.phase;
    assign eff_zo    = (st.phase == PH_LEAD) ? 1'b0 : st.zeros_only;

    always_comb begin
        step.n   = 2'd0;
        step.r0  = fin(1'b0);
        step.r1  = fin(1'b0);
        step.nxt = st;
        if (st.phase == PH_LEAD && (is_nul || is_spc || ch == CH_MINUS || ch == CH_PLUS)) begin
            // whitespace, signs and empty string
            if (is_nul) begin
                step.n   = 2'd1;
                step.r0  = fin(1'b0);
            end else if (!is_spc) begin
                step.nxt.phase      = PH_LZ;
                step.nxt.zeros_only = 1'b0;
                if (ch == CH_MINUS) begin
                    step.n  = 2'd1;
                    step.r0 = chr(CH_MINUS);
                end
            end
        end else begin
            step.nxt.zeros_only = eff_zo;
            case (eff_phase)
                PH_LZ: begin
                    if (is_nul) begin
                        if (eff_zo) begin
                            step.n  = 2'd2;
                            step.r0 = chr(CH_ZERO);
                            step.r1 = fin(1'b1);
                        end else begin
                            step.n  = 2'd1;
                            step.r0 = fin(1'b0);
                        end
                    end else if (ch == CH_ZERO) begin
                        step.nxt.phase      = PH_LZ;
                        step.nxt.zeros_only = 1'b1;
                    end else if (is_dig) begin
                        step.nxt.phase = PH_INT;
                        step.n         = 2'd1;
                        step.r0        = chr(ch);
                    end else if (ch == CH_DOT) begin
                        step.nxt.need_frac = ~eff_zo;
                        step.nxt.phase     = PH_FRAC;
                        step.n             = 2'd2;
                        step.r0            = chr(CH_ZERO);
                        step.r1            = chr(CH_DOT);
                    end else if (is_em) begin
                        step.nxt.phase = PH_EXPS;
                        step.n         = 2'd2;
                        step.r0        = chr(eff_zo ? CH_ZERO : CH_ONE);
                        step.r1        = chr(ch);
                    end else begin
                        step.nxt.phase = PH_DRAIN;
                    end
                end
                PH_INT: begin
                    if (is_nul) begin
                        step.n  = 2'd1;
                        step.r0 = fin(1'b1);
                    end else if (is_dig) begin
                        step.n  = 2'd1;
                        step.r0 = chr(ch);
                    end else if (ch == CH_DOT) begin
                        step.nxt.need_frac = 1'b0;
                        step.nxt.phase     = PH_FRAC;
                        step.n             = 2'd1;
                        step.r0            = chr(ch);
                    end else if (is_em) begin
                        step.nxt.phase = PH_EXPS;
                        step.n         = 2'd1;
                        step.r0        = chr(ch);
                    end else begin
                        step.nxt.phase = PH_DRAIN;
                    end
                end
                PH_FRAC: begin
                    if (is_nul) begin
                        step.n  = 2'd1;
                        step.r0 = fin(~st.need_frac);
                    end else if (is_dig) begin
                        step.nxt.need_frac = 1'b0;
                        step.n             = 2'd1;
                        step.r0            = chr(ch);
                    end else if (is_em && !st.need_frac) begin
                        step.nxt.phase = PH_EXPS;
                        step.n         = 2'd1;
                        step.r0        = chr(ch);
                    end else begin
                        step.nxt.phase = PH_DRAIN;
                    end
                end
                PH_EXPS: begin
                    if (is_nul) begin
                        step.n  = 2'd1;
                        step.r0 = fin(1'b1);
                    end else if (ch == CH_PLUS || ch == CH_MINUS || is_dig) begin
                        step.nxt.phase = PH_EXP;
                        step.n         = 2'd1;
                        step.r0        = chr(ch);
                    end else begin
                        step.nxt.phase = PH_DRAIN;
                    end
                end
                PH_EXP: begin
                    if (is_nul) begin
                        step.n  = 2'd1;
                        step.r0 = fin(1'b1);
                    end else if (is_dig) begin
                        step.n  = 2'd1;
                        step.r0 = chr(ch);
                    end else begin
                        step.nxt.phase = PH_DRAIN;
                    end
                end
                default: begin
                    step.nxt.phase = PH_DRAIN;
                    if (is_nul) begin
                        step.n  = 2'd1;
                        step.r0 = fin(1'b0);
                    end
                end
            endcase
        end
        // an end result returns everything to reset
        if (is_nul) begin
            step.nxt.phase      = PH_LEAD;
            step.nxt.zeros_only = 1'b0;
            step.nxt.need_frac  = 1'b0;
        end
    end

endmodule

[rtl/core/nmt_outq.sv]
// small result queue: takes up to two results per cycle, gives one per beat
// depends on nmt_pkg
module nmt_outq import nmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  result_t    push_r0,
    input  result_t    push_r1,
    output logic       room2,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    head
);

    result_t          q_reg [QDEPTH];
    logic [QAW-1:0]   wr_reg, wr_next;
    logic [QAW-1:0]   rd_reg, rd_next;
    logic [QAW:0]     cnt_reg, cnt_next;
    logic [QAW-1:0]   wr_p1;
    logic             pop;

    assign m_valid = (cnt_reg != '0);
    assign room2   = (cnt_reg <= (QAW+1)'(QDEPTH - 2));
    assign head    = q_reg[rd_reg];
    assign pop     = m_valid && m_ready;
    assign wr_p1   = wr_reg + 1'b1;

    // pointer and count update
    always_comb begin
        wr_next  = wr_reg + QAW'(push_n);
        rd_next  = rd_reg + QAW'(pop);
        cnt_next = cnt_reg + (QAW+1)'(push_n) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry writes
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_reg] <= push_r0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_p1] <= push_r1;
        end
    end

endmodule

[rtl/core/numeric_text_normalizer.sv]
// top level of the numeric text normalizer: parser state, step logic, result queue
// depends on nmt_pkg, nmt_step, nmt_outq
//
//  channel | dir | ports                                        | beat
//  s_      | in  | s_valid s_ready s_in_char                    | one string byte
//  m_      | out | m_valid m_ready m_out_char m_is_char         | one result
//          |     | m_is_end m_accepted                          |
//
// one byte is taken per cycle while s_ready is high; each byte yields zero, one
// or two results, which drain one per cycle while m_ready is high through a
// four-entry result queue. s_ready drops only while the queue lacks room for two
// results; the input stalls only once results back up, from receiver stalls or
// bursts of two-result bytes.
// reset (aresetn low, synchronous) returns the parser to leading whitespace
// and empties the queue.
module numeric_text_normalizer import nmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_is_char,
    output logic       m_is_end,
    output logic       m_accepted
);

    parse_state_t st_reg, st_next;
    step_t        step;
    logic         take;
    logic         room2;
    logic [1:0]   push_n;
    result_t      head;

    assign s_ready = room2;
    assign take    = s_valid && room2;
    assign push_n  = take ? step.n : 2'd0;

    nmt_step u_step (
        .st   (st_reg),
        .ch   (s_in_char),
        .step (step)
    );

    // parser state advances on each accepted beat
    assign st_next = take ? step.nxt : st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_LEAD, zeros_only: 1'b0, need_frac: 1'b0};
        end else begin
            st_reg <= st_next;
        end
    end

    nmt_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .push_r0 (step.r0),
        .push_r1 (step.r1),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_char = head.out_char;
    assign m_is_char  = head.is_char;
    assign m_is_end   = head.is_end;
    assign m_accepted = head.accepted;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for numeric_text_normalizer: directed strings, then random number text
// depends on nmt_pkg and the numeric_text_normalizer rtl only

module tb;
    import nmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;
    localparam int BYTES_PER_LEG  = 245;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char  = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_char;
    logic       m_is_char;
    logic       m_is_end;
    logic       m_accepted;

    // predictor state, mirrors the parse of the block
    logic [3:0] parse_phase = PH_LEAD;
    logic       zeros_only  = 1'b0;
    logic       need_frac   = 1'b0;

    result_t    expected_results[$];
    logic [7:0] text_buf[$];

    int src_idle_pct     = 0;
    int dst_idle_pct     = 0;
    int mismatches       = 0;
    int results_checked  = 0;
    int bytes_in         = 0;
    int strings_ok       = 0;
    int strings_rejected = 0;
    int quiet_cycles     = 0;

    numeric_text_normalizer uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_is_char  (m_is_char),
        .m_is_end   (m_is_end),
        .m_accepted (m_accepted)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_emark(input logic [7:0] c);
        return c == CH_LE || c == CH_UE;
    endfunction

    task automatic emit_char(input logic [7:0] c);
        result_t r;
        r.out_char = c;
        r.is_char  = 1'b1;
        r.is_end   = 1'b0;
        r.accepted = 1'b0;
        expected_results.push_back(r);
    endtask

    // end beat closes the string and restarts the parse
    task automatic close_string(input logic ok);
        result_t r;
        r.out_char = CH_NUL;
        r.is_char  = 1'b0;
        r.is_end   = 1'b1;
        r.accepted = ok;
        expected_results.push_back(r);
        parse_phase = PH_LEAD;
        zeros_only  = 1'b0;
        need_frac   = 1'b0;
        if (ok) strings_ok++;
        else strings_rejected++;
    endtask

    // expected beats for one accepted string byte
    task automatic normalize_byte(input logic [7:0] c);
        if (parse_phase == PH_LEAD) begin
            if (c == CH_NUL) begin
                close_string(1'b0);
                return;
            end
            if (is_blank(c)) return;
            parse_phase = PH_LZ;
            zeros_only  = 1'b0;
            if (c == CH_MINUS) begin
                emit_char(CH_MINUS);
                return;
            end
            if (c == CH_PLUS) return;
        end
        case (parse_phase)
            PH_LZ: begin
                if (c == CH_NUL) begin
                    // a run of zeros alone stands for the digit zero
                    if (zeros_only) emit_char(CH_ZERO);
                    close_string(zeros_only);
                end else if (c == CH_ZERO) begin
                    zeros_only = 1'b1;
                end else if (is_digit(c)) begin
                    parse_phase = PH_INT;
                    emit_char(c);
                end else if (c == CH_DOT) begin
                    need_frac   = !zeros_only;
                    parse_phase = PH_FRAC;
                    emit_char(CH_ZERO);
                    emit_char(CH_DOT);
                end else if (is_emark(c)) begin
                    emit_char(zeros_only ? CH_ZERO : CH_ONE);
                    parse_phase = PH_EXPS;
                    emit_char(c);
                end else begin
                    parse_phase = PH_DRAIN;
                end
            end
            PH_INT: begin
                if (c == CH_NUL) begin
                    close_string(1'b1);
                end else if (is_digit(c)) begin
                    emit_char(c);
                end else if (c == CH_DOT) begin
                    need_frac   = 1'b0;
                    parse_phase = PH_FRAC;
                    emit_char(c);
                end else if (is_emark(c)) begin
                    parse_phase = PH_EXPS;
                    emit_char(c);
                end else begin
                    parse_phase = PH_DRAIN;
                end
            end
            PH_FRAC: begin
                if (c == CH_NUL) begin
                    close_string(!need_frac);
                end else if (is_digit(c)) begin
                    need_frac = 1'b0;
                    emit_char(c);
                end else if (is_emark(c) && !need_frac) begin
                    parse_phase = PH_EXPS;
                    emit_char(c);
                end else begin
                    parse_phase = PH_DRAIN;
                end
            end
            PH_EXPS: begin
                if (c == CH_NUL) begin
                    close_string(1'b1);
                end else if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
                    parse_phase = PH_EXP;
                    emit_char(c);
                end else begin
                    parse_phase = PH_DRAIN;
                end
            end
            PH_EXP: begin
                if (c == CH_NUL) close_string(1'b1);
                else if (is_digit(c)) emit_char(c);
                else parse_phase = PH_DRAIN;
            end
            default: begin
                if (c == CH_NUL) close_string(1'b0);
                else parse_phase = PH_DRAIN;
            end
        endcase
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_result();
        result_t got;
        result_t want;
        got.out_char = m_out_char;
        got.is_char  = m_is_char;
        got.is_end   = m_is_end;
        got.accepted = m_accepted;
        results_checked++;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: char %02h is_char %0b is_end %0b accepted %0b",
                         got.out_char, got.is_char, got.is_end, got.accepted);
        end else begin
            want = expected_results.pop_front();
            if (got.out_char !== want.out_char || got.is_char !== want.is_char ||
                got.is_end !== want.is_end || got.accepted !== want.accepted) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected char %02h is_char %0b is_end %0b acc %0b,",
                              " got char %02h is_char %0b is_end %0b acc %0b"},
                             results_checked, want.out_char, want.is_char, want.is_end,
                             want.accepted, got.out_char, got.is_char, got.is_end,
                             got.accepted);
            end
        end
    endtask

    // monitor: predict on input beats, check output beats, watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready) begin
                normalize_byte(s_in_char);
                bytes_in++;
            end
            if (m_valid && m_ready) begin
                check_result();
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_results.size());
                $display("[numeric_text_normalizer] ERROR");
                $finish;
            end
        end
    end

    // send one string byte, idling first at the sender's rate
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid   <= 1'b0;
            s_in_char <= 8'($urandom);
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(CH_NUL);
    endtask

    // random number text, mostly well formed, some broken or pure noise
    task automatic build_number();
        text_buf.delete();
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 1)) text_buf.push_back(CH_SPACE);
                else text_buf.push_back(CH_TAB + 8'($urandom_range(0, 4)));
            end
            case ($urandom_range(0, 3))
                0: text_buf.push_back(CH_MINUS);
                1: text_buf.push_back(CH_PLUS);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(CH_ZERO);
            repeat ($urandom_range(0, 4)) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
                text_buf.push_back(CH_DOT);
                repeat ($urandom_range(0, 3))
                    text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 2) == 0) begin
                text_buf.push_back($urandom_range(0, 1) ? CH_LE : CH_UE);
                case ($urandom_range(0, 2))
                    0: text_buf.push_back(CH_MINUS);
                    1: text_buf.push_back(CH_PLUS);
                    default: ;
                endcase
                repeat ($urandom_range(0, 3))
                    text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            // occasionally corrupt one byte
            if ($urandom_range(0, 9) == 0 && text_buf.size() > 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
        end
        text_buf.push_back(CH_NUL);
    endtask

    // hand-picked strings covering every rule and rejection path
    task automatic test_directed_cases();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        send_string("");
        send_string(" ");
        send_string("+");
        send_string("-");
        send_string("0");
        send_string("000");
        send_string("-0");
        send_string("0e5");
        send_string("007");
        send_string("+12.50");
        send_string(".5");
        send_string("-.5");
        send_string("00.5");
        send_string("5.");
        send_string(".");
        send_string("-.");
        send_string("e5");
        send_string("E");
        send_string("1e");
        send_string("1e+");
        send_string("1E-7");
        send_string("1.e3");
        send_string(".e5");
        send_string("1x");
        send_string("1.2.3");
        send_string("--1");
        send_string("1e5.2");
        // every whitespace byte ahead of digits
        for (int c = CH_TAB; c <= CH_CR; c++) send_byte(8'(c));
        send_string(" 42");
        // top-bit bytes
        send_byte(8'hFF);
        send_byte(CH_NUL);
        send_string("9");
        send_byte(8'h80);
        send_byte(CH_NUL);
    endtask

    task automatic test_random_strings(input int src_pct, input int dst_pct,
                                       input int byte_count);
        int start;
        start        = bytes_in;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        while (bytes_in - start < byte_count) begin
            build_number();
            foreach (text_buf[i]) send_byte(text_buf[i]);
        end
    endtask

    // sender holds off until the output side has caught up
    task automatic test_pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_pause_until_drained();
        test_random_strings(19, 86, BYTES_PER_LEG);
        test_pause_until_drained();
        test_random_strings(86, 19, BYTES_PER_LEG);
        test_pause_until_drained();
        test_random_strings(0, 0, BYTES_PER_LEG);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d input bytes: %0d strings accepted, %0d rejected",
                 bytes_in, strings_ok, strings_rejected);
        $display("checked %0d result beats, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[numeric_text_normalizer] OK");
        end else begin
            $display("[numeric_text_normalizer] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/nmt_pkg.sv
rtl/core/nmt_step.sv
rtl/core/nmt_outq.sv
rtl/core/numeric_text_normalizer.sv
bench/tb.sv
